// ----- design/uart_rb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types, constants and helpers of the 16550-style UART register block.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		KIND_READ   = 3'd0,
		KIND_WRITE  = 3'd1,
		KIND_RX     = 3'd2,
		KIND_TX_RDY = 3'd3,
		KIND_MODEM  = 3'd4
	} kind_t;

	localparam logic [2:0] ADDR_RBR = 3'd0;
	localparam logic [2:0] ADDR_IER = 3'd1;
	localparam logic [2:0] ADDR_IIR = 3'd2;
	localparam logic [2:0] ADDR_LCR = 3'd3;
	localparam logic [2:0] ADDR_MCR = 3'd4;
	localparam logic [2:0] ADDR_LSR = 3'd5;
	localparam logic [2:0] ADDR_MSR = 3'd6;
	localparam logic [2:0] ADDR_SCR = 3'd7;

	localparam logic [3:0] IIR_LINE     = 4'h6;
	localparam logic [3:0] IIR_RXD      = 4'h4;
	localparam logic [3:0] IIR_TX_EMPTY = 4'h2;
	localparam logic [3:0] IIR_MODEM    = 4'h0;
	localparam logic [3:0] IIR_NO_INT   = 4'h1;
	localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;
	localparam int DLAB_BIT = 7;

	typedef struct packed {
		logic [3:0] ier;
		logic       line_err;
		logic       rx_trig;
		logic       thre;
		logic       modem_delta;
	} irq_src_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (int'(p) == FIFO_DEPTH - 1) r = '0;
		else r = ptr_t'(int'(p) + 1);
		return r;
	endfunction

	function automatic ptr_t ptr_add(input ptr_t p, input cnt_t c);
		logic [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(c);
		if (int'(s) >= FIFO_DEPTH) s = s - SUM_W'(FIFO_DEPTH);
		return s[PTR_W-1:0];
	endfunction

	function automatic cnt_t rx_trigger(input logic [2:0] mode);
		int t;
		cnt_t r;
		unique case (mode[2:1])
			2'd0: t = 1;
			2'd1: t = 4;
			2'd2: t = 8;
			default: t = 14;
		endcase
		if (t > FIFO_DEPTH) t = FIFO_DEPTH;
		r = mode[0] ? CNT_W'(t) : CNT_W'(1);
		return r;
	endfunction

endpackage

// ----- design/uart_rb_irq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rb_irq
// Interrupt priority encoder: line status, rx data, THRE, modem.
// ----------------------------------------------------------------------------
module uart_rb_irq (
	input  uart_rb_pkg::irq_src_t src,
	output logic [3:0]            code
);
	always_comb begin
		priority if (src.ier[2] && src.line_err) code = uart_rb_pkg::IIR_LINE;
		else if (src.ier[0] && src.rx_trig) code = uart_rb_pkg::IIR_RXD;
		else if (src.ier[1] && src.thre) code = uart_rb_pkg::IIR_TX_EMPTY;
		else if (src.ier[3] && src.modem_delta) code = uart_rb_pkg::IIR_MODEM;
		else code = uart_rb_pkg::IIR_NO_INT;
	end
endmodule

// ----- design/uart_register_block_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_block_unit
// Register side of a 16550-style UART with rx/tx FIFOs and interrupt logic.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each event is handled by the logic in front of the
// result register, so a new beat is taken every cycle; a result waits in that
// register while out_stall is high, and in_stall then holds the input. A result
// shows in the cycle after its beat. divisor, line_control and modem_out show
// the register values after the beat that is presented on the output.
module uart_register_block_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [2:0]  addr,
	input  logic [7:0]  wdata,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  rx_errors,
	input  logic [3:0]  modem_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  rdata,
	output logic        irq_out,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic [15:0] divisor,
	output logic [7:0]  line_control,
	output logic [3:0]  modem_out
);
	localparam int DEPTH = uart_rb_pkg::FIFO_DEPTH;

	logic [7:0] rx_data_q [DEPTH];
	logic [2:0] rx_err_q  [DEPTH];
	logic [7:0] tx_data_q [DEPTH];

	uart_rb_pkg::ptr_t rx_head_q, tx_head_q, n_rx_head, n_tx_head;
	uart_rb_pkg::cnt_t rx_count_q, tx_count_q, err_cnt_q;
	uart_rb_pkg::cnt_t n_rx_count, n_tx_count, n_err_cnt;
	logic [3:0]  ier_q, n_ier;
	logic [7:0]  lcr_q, n_lcr;
	logic [5:0]  mcr_q, n_mcr;
	logic [15:0] dl_q, n_dl;
	logic [2:0]  fmode_q, n_fmode;
	logic [3:0]  lerr_q, n_lerr;
	logic [3:0]  mdelta_q, n_mdelta;
	logic [3:0]  mlevel_q, n_mlevel;
	logic        thre_q, n_thre;
	logic [7:0]  scr_q, n_scr;

	logic        rx_we, tx_we;
	uart_rb_pkg::ptr_t rx_waddr, tx_waddr;

	logic        out_valid_q, rd_tx_valid;
	logic [7:0]  rdata_q, tx_byte_q, rd_data, rd_tx_byte;
	logic        irq_q;
	logic        tx_valid_q;

	logic        accept, fifo_on, dlab, rx_full, tx_full;
	uart_rb_pkg::cnt_t cap, tx_after;
	uart_rb_pkg::irq_src_t src_cur, src_nxt;
	logic [3:0]  code_cur, code_nxt;
	logic [7:0]  lsr;

	assign accept   = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall;
	assign fifo_on  = fmode_q[0];
	assign dlab     = lcr_q[uart_rb_pkg::DLAB_BIT];
	assign cap      = fifo_on ? uart_rb_pkg::CNT_W'(DEPTH) : uart_rb_pkg::CNT_W'(1);
	assign rx_full  = rx_count_q >= cap;
	assign tx_full  = tx_count_q >= cap;

	assign src_cur.ier         = ier_q;
	assign src_cur.line_err    = lerr_q != '0;
	assign src_cur.rx_trig     = rx_count_q != '0 && rx_count_q >= uart_rb_pkg::rx_trigger(fmode_q);
	assign src_cur.thre        = thre_q;
	assign src_cur.modem_delta = mdelta_q != '0;

	assign src_nxt.ier         = n_ier;
	assign src_nxt.line_err    = n_lerr != '0;
	assign src_nxt.rx_trig     = n_rx_count != '0 && n_rx_count >= uart_rb_pkg::rx_trigger(n_fmode);
	assign src_nxt.thre        = n_thre;
	assign src_nxt.modem_delta = n_mdelta != '0;

	uart_rb_irq u_irq_cur (.src(src_cur), .code(code_cur));
	uart_rb_irq u_irq_nxt (.src(src_nxt), .code(code_nxt));

	assign lsr = {fifo_on && err_cnt_q != '0, {2{tx_count_q == '0}}, lerr_q, rx_count_q != '0};
	assign tx_after = tx_count_q - uart_rb_pkg::CNT_W'(1);

	always_comb begin
		n_rx_head = rx_head_q; n_rx_count = rx_count_q; n_err_cnt = err_cnt_q;
		n_tx_head = tx_head_q; n_tx_count = tx_count_q;
		n_ier = ier_q; n_lcr = lcr_q; n_mcr = mcr_q; n_dl = dl_q; n_fmode = fmode_q;
		n_lerr = lerr_q; n_mdelta = mdelta_q; n_mlevel = mlevel_q; n_thre = thre_q;
		n_scr = scr_q;
		rx_we = 1'b0; rx_waddr = uart_rb_pkg::ptr_add(rx_head_q, rx_count_q);
		tx_we = 1'b0; tx_waddr = uart_rb_pkg::ptr_add(tx_head_q, tx_count_q);
		rd_data = '0; rd_tx_valid = 1'b0; rd_tx_byte = '0;
		unique case (kind)
			uart_rb_pkg::KIND_READ: begin
				unique case (addr)
					uart_rb_pkg::ADDR_RBR: begin
						if (dlab) rd_data = dl_q[7:0];
						else if (rx_count_q != '0) begin
							rd_data    = rx_data_q[rx_head_q];
							n_rx_head  = uart_rb_pkg::ptr_inc(rx_head_q);
							n_rx_count = rx_count_q - uart_rb_pkg::CNT_W'(1);
							if (rx_err_q[rx_head_q] != '0)
								n_err_cnt = err_cnt_q - uart_rb_pkg::CNT_W'(1);
							if (n_rx_count != '0)
								n_lerr = lerr_q | {rx_err_q[n_rx_head], 1'b0};
						end
					end
					uart_rb_pkg::ADDR_IER: rd_data = dlab ? dl_q[15:8] : {4'd0, ier_q};
					uart_rb_pkg::ADDR_IIR: begin
						if (code_cur == uart_rb_pkg::IIR_TX_EMPTY) n_thre = 1'b0;
						rd_data = {4'd0, code_cur} | (fifo_on ? uart_rb_pkg::IIR_FIFO_BITS : 8'd0);
					end
					uart_rb_pkg::ADDR_LCR: rd_data = lcr_q;
					uart_rb_pkg::ADDR_MCR: rd_data = {2'd0, mcr_q};
					uart_rb_pkg::ADDR_LSR: begin
						rd_data = lsr;
						n_lerr  = '0;
					end
					uart_rb_pkg::ADDR_MSR: begin
						rd_data  = {mlevel_q, mdelta_q};
						n_mdelta = '0;
					end
					default: rd_data = scr_q;
				endcase
			end
			uart_rb_pkg::KIND_WRITE: begin
				unique case (addr)
					uart_rb_pkg::ADDR_RBR: begin
						if (dlab) n_dl[7:0] = wdata;
						else begin
							n_thre = 1'b0;
							if (!tx_full) begin
								tx_we      = 1'b1;
								n_tx_count = tx_count_q + uart_rb_pkg::CNT_W'(1);
							end
						end
					end
					uart_rb_pkg::ADDR_IER: begin
						if (dlab) n_dl[15:8] = wdata;
						else begin
							if (wdata[1] && tx_count_q == '0) n_thre = 1'b1;
							n_ier = wdata[3:0];
						end
					end
					uart_rb_pkg::ADDR_IIR: begin
						if (wdata[0] != fmode_q[0]) begin
							n_rx_head = '0; n_rx_count = '0; n_err_cnt = '0;
							n_tx_head = '0; n_tx_count = '0; n_thre = 1'b1;
						end
						if (wdata[0]) begin
							n_fmode = {wdata[7:6], 1'b1};
							if (wdata[1]) begin
								n_rx_head = '0; n_rx_count = '0; n_err_cnt = '0;
							end
							if (wdata[2]) begin
								n_tx_head = '0; n_tx_count = '0; n_thre = 1'b1;
							end
						end else n_fmode = {fmode_q[2:1], 1'b0};
					end
					uart_rb_pkg::ADDR_LCR: n_lcr = wdata;
					uart_rb_pkg::ADDR_MCR: n_mcr = wdata[5:0];
					uart_rb_pkg::ADDR_SCR: n_scr = wdata;
					default: ;
				endcase
			end
			uart_rb_pkg::KIND_RX: begin
				if (rx_full) begin
					n_lerr[0] = 1'b1;
					if (!fifo_on) begin
						rx_we    = 1'b1;
						rx_waddr = rx_head_q;
						n_lerr   = n_lerr | {rx_errors, 1'b0};
						n_err_cnt = err_cnt_q
							- uart_rb_pkg::CNT_W'(rx_err_q[rx_head_q] != '0)
							+ uart_rb_pkg::CNT_W'(rx_errors != '0);
					end
				end else begin
					rx_we      = 1'b1;
					n_rx_count = rx_count_q + uart_rb_pkg::CNT_W'(1);
					n_err_cnt  = err_cnt_q + uart_rb_pkg::CNT_W'(rx_errors != '0);
					if (rx_count_q == '0) n_lerr = lerr_q | {rx_errors, 1'b0};
				end
			end
			uart_rb_pkg::KIND_TX_RDY: begin
				if (tx_count_q != '0) begin
					rd_tx_valid = 1'b1;
					rd_tx_byte  = tx_data_q[tx_head_q];
					n_tx_head   = uart_rb_pkg::ptr_inc(tx_head_q);
					n_tx_count  = tx_after;
					if (tx_after == '0) n_thre = 1'b1;
				end
			end
			uart_rb_pkg::KIND_MODEM: begin
				n_mdelta = mdelta_q | ((modem_in ^ mlevel_q) & 4'hB)
					| ((mlevel_q & ~modem_in) & 4'h4);
				n_mlevel = modem_in;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && rx_we) begin
			rx_data_q[rx_waddr] <= rx_byte;
			rx_err_q[rx_waddr]  <= rx_errors;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && tx_we) tx_data_q[tx_waddr] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0; rx_count_q <= '0; err_cnt_q <= '0;
			tx_head_q <= '0; tx_count_q <= '0;
			ier_q <= '0; lcr_q <= '0; mcr_q <= '0; dl_q <= '0; fmode_q <= '0;
			lerr_q <= '0; mdelta_q <= '0; mlevel_q <= '0; thre_q <= 1'b0; scr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rx_head_q <= n_rx_head; rx_count_q <= n_rx_count; err_cnt_q <= n_err_cnt;
				tx_head_q <= n_tx_head; tx_count_q <= n_tx_count;
				ier_q <= n_ier; lcr_q <= n_lcr; mcr_q <= n_mcr; dl_q <= n_dl;
				fmode_q <= n_fmode; lerr_q <= n_lerr; mdelta_q <= n_mdelta;
				mlevel_q <= n_mlevel; thre_q <= n_thre; scr_q <= n_scr;
			end
			if (!in_stall) out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q   <= rd_data;
			irq_q     <= code_nxt != uart_rb_pkg::IIR_NO_INT;
			tx_byte_q <= rd_tx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tx_valid_q <= 1'b0;
		else if (accept) tx_valid_q <= rd_tx_valid;
	end

	assign out_valid    = out_valid_q;
	assign rdata        = rdata_q;
	assign irq_out      = irq_q;
	assign tx_valid     = tx_valid_q;
	assign tx_byte      = tx_byte_q;
	assign divisor      = dl_q;
	assign line_control = lcr_q;
	assign modem_out    = mcr_q[3:0];

	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(rx_count_q) <= DEPTH && int'(tx_count_q) <= DEPTH)
		else $error("fifo count beyond depth");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_on |-> (rx_count_q <= uart_rb_pkg::CNT_W'(1) && tx_count_q <= uart_rb_pkg::CNT_W'(1)))
		else $error("fifo off holds more than one byte");
	a_errcnt: assert property (@(posedge clk) disable iff (!arst_n)
		err_cnt_q <= rx_count_q)
		else $error("error count exceeds rx count");
endmodule
